FILE: sv/assert_macros.svh
// Assertion macros shared by the scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bsc_pkg.sv
// Shared types and constants of the byte signature scanner.
`default_nettype none

package bsc_pkg;

  localparam int BYTE_W            = 8;
  localparam int CAPTURE_BYTES     = 8;
  localparam int MAX_DISTANCE      = 255;
  localparam int SIG_MAX_DEF       = 16;
  localparam int HISTORY_DEPTH_DEF = 512;

  // register field widths
  localparam int DIST_W     = 8;
  localparam int SIG_LEN_W  = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int ADDR_W     = 64;

  // internal arithmetic widths
  localparam int CD_W    = 9;   // capture countdown, up to distance + 7
  localparam int BACK_W  = 10;  // look-back from current byte, up to 277
  localparam int DELTA_W = 11;  // signed offset from position to address

  // result queue
  localparam int OUT_DEPTH = 4;
  localparam int OPTR_W    = $clog2(OUT_DEPTH);
  localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_OUTSIDE   = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIG_LOW      = 3'd0,
    REG_SIG_HIGH     = 3'd1,
    REG_SIG_LEN      = 3'd2,
    REG_DISTANCE     = 3'd3,
    REG_AFTER_MATCH  = 3'd4,
    REG_WANT_DATA    = 3'd5,
    REG_BASE_ADDRESS = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] mem_byte;
    logic              region_end;
  } scan_in_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] match_address;
    logic [ADDR_W-1:0] data_value;
  } scan_out_t;

endpackage

`default_nettype wire

FILE: sv/bsc_cell.sv
// One window cell: holds a byte, passes it on and compares it against its signature byte.
`default_nettype none

module bsc_cell
  import bsc_pkg::*;
(
  input  logic              clk,
  input  logic              shift,
  input  logic              active,
  input  logic [BYTE_W-1:0] sig_byte,
  input  logic [BYTE_W-1:0] byte_in,
  input  logic              hit_in,
  output logic [BYTE_W-1:0] byte_q,
  output logic              hit_out
);

  // byte moves one cell further on every accepted transaction
  always_ff @(posedge clk) begin
    if (shift) begin
      byte_q <= byte_in;
    end
  end

  // cells beyond the signature length always agree
  assign hit_out = hit_in & (~active | (byte_in == sig_byte));

endmodule

`default_nettype wire

FILE: sv/bsc_ram.sv
// Generic single-write, single-read RAM with registered read (old data on collision).
`default_nettype none

module bsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: sv/bsc_out_fifo.sv
// Small result queue between the scan pipeline and the result channel.
`default_nettype none

module bsc_out_fifo
  import bsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  scan_out_t         push_item,
  input  logic              pop,
  output logic              valid,
  output scan_out_t         head,
  output logic [OCNT_W-1:0] count
);

  scan_out_t         slots [OUT_DEPTH];
  logic [OPTR_W-1:0] wr_ptr;
  logic [OPTR_W-1:0] rd_ptr;
  logic [OCNT_W-1:0] count_next;

  // occupancy after this cycle's push and pop
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + OCNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - OCNT_W'(1);
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OPTR_W'(1);
      end
      count <= count_next;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

endmodule

`default_nettype wire

FILE: sv/byte_signature_scanner.sv
// A result passes stage 1, stage 2 and the result queue before result_valid offers it.
// One byte per cycle while not stalled; the signature window is a chain of compare cells.
// The 4-entry result queue gives the credit; byte_stall rises only when it and the
// two pipeline stages could hold no further result.
// Reset (rst, synchronous): config to reset values, scan state, pipeline and queue cleared.
// The history RAM is not cleared; only bytes of the current region are ever read.
`default_nettype none
`include "assert_macros.svh"

module byte_signature_scanner
  import bsc_pkg::*;
#(
  parameter int SIG_MAX       = SIG_MAX_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  scan_in_t              byte_item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output scan_out_t             result_item,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LEN_W  = $clog2(SIG_MAX + 1);
  localparam int BANKS  = CAPTURE_BYTES;
  localparam int BANK_W = $clog2(BANKS);
  localparam int ROWS   = (HISTORY_DEPTH + BANKS - 1) / BANKS;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int RING   = ROWS * BANKS;
  localparam int SLOT_W = BANK_W + ROW_W;
  localparam int SUB_W  = ((SLOT_W > BACK_W) ? SLOT_W : BACK_W) + 1;
  localparam int SIG_W  = SIG_MAX * BYTE_W;

  typedef struct packed {
    status_t             status;
    logic                capture;
    logic                addr_mode;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   position;
    logic [DELTA_W-1:0]  delta;
  } tok1_t;

  typedef struct packed {
    status_t             status;
    logic                capture;
    logic                addr_mode;
    logic [BANK_W-1:0]   bank;
    logic [ADDR_W-1:0]   offset;
  } tok2_t;

  // configuration registers
  logic [63:0]          sig_low;
  logic [63:0]          sig_high;
  logic [SIG_LEN_W-1:0] sig_len;
  logic [DIST_W-1:0]    distance;
  logic                 after_match;
  logic                 want_data;
  logic [ADDR_W-1:0]    base_address;

  // scan state
  logic [ADDR_W-1:0] position;
  logic              found;
  logic              reported;
  logic [CD_W-1:0]   cd;
  logic [SLOT_W-1:0] wr_slot;

  logic [ADDR_W-1:0] position_next;
  logic              found_next;
  logic              reported_next;
  logic [CD_W-1:0]   cd_next;
  logic [SLOT_W-1:0] wr_slot_next;
  logic [CD_W-1:0]   cd_dec;

  logic              accept;
  logic              last_byte;
  logic [LEN_W-1:0]  len;
  logic [DIST_W-1:0] dist_sat;
  logic              pos_ok;
  logic              hit;

  // window cells
  logic [2*64-1:0]   sig_all;
  logic [SIG_W-1:0]  rev_sig;
  logic [SIG_W-1:0]  aligned_sig;
  logic [LEN_W-1:0]  sig_shift;
  logic [BYTE_W-1:0] chain [SIG_MAX];
  logic              hit_chain [SIG_MAX+1];
  logic              active [SIG_MAX];

  // per-byte decision
  logic              res_valid;
  status_t           res_status;
  logic              res_capture;
  logic              res_addr_mode;
  logic [BACK_W-1:0] res_back;
  logic [BACK_W-1:0] back_before;
  logic [BACK_W-1:0] back_after;
  logic [DELTA_W-1:0] res_delta;
  logic [SUB_W-1:0]  slot_sub;
  logic [SLOT_W-1:0] first_slot;

  // pipeline
  logic              t1_valid;
  tok1_t             t1;
  logic              t2_valid;
  tok2_t             t2;
  logic [ROW_W-1:0]  rd_row [BANKS];
  logic [BYTE_W-1:0] ram_q [BANKS];
  logic [ADDR_W-1:0] captured;
  scan_out_t         push_item;

  // result queue
  logic              pop;
  logic [OCNT_W-1:0] q_count;
  logic [OCNT_W:0]   queued;

  assign accept    = byte_valid && !byte_stall;
  assign last_byte = byte_item.region_end;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sig_low      <= '0;
      sig_high     <= '0;
      sig_len      <= SIG_LEN_W'(1);
      distance     <= '0;
      after_match  <= 1'b0;
      want_data    <= 1'b0;
      base_address <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SIG_LOW:      sig_low      <= cfg_data;
        REG_SIG_HIGH:     sig_high     <= cfg_data;
        REG_SIG_LEN:      sig_len      <= cfg_data[SIG_LEN_W-1:0];
        REG_DISTANCE:     distance     <= cfg_data[DIST_W-1:0];
        REG_AFTER_MATCH:  after_match  <= cfg_data[0];
        REG_WANT_DATA:    want_data    <= cfg_data[0];
        REG_BASE_ADDRESS: base_address <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective length and distance
  always_comb begin
    if (sig_len == '0) begin
      len = LEN_W'(1);
    end else if (32'(sig_len) > SIG_MAX) begin
      len = LEN_W'(SIG_MAX);
    end else begin
      len = LEN_W'(sig_len);
    end
    if (32'(distance) > MAX_DISTANCE) begin
      dist_sat = DIST_W'(MAX_DISTANCE);
    end else begin
      dist_sat = distance;
    end
  end

  // signature aligned to cell order: cell i needs signature byte len-1-i
  assign sig_all   = {sig_high, sig_low};
  assign sig_shift = LEN_W'(SIG_MAX) - len;

  for (genvar m = 0; m < SIG_MAX; m++) begin : g_rev
    assign rev_sig[m*BYTE_W +: BYTE_W] = sig_all[(SIG_MAX-1-m)*BYTE_W +: BYTE_W];
  end

  assign aligned_sig = rev_sig >> (sig_shift * BYTE_W);

  // chain of compare cells, cell 0 sees the incoming byte
  assign chain[0]     = byte_item.mem_byte;
  assign hit_chain[0] = 1'b1;

  for (genvar i = 0; i < SIG_MAX; i++) begin : g_cell
    assign active[i] = (LEN_W'(i) < len);
    if (i < SIG_MAX - 1) begin : g_mid
      bsc_cell u_cell (
        .clk      (clk),
        .shift    (accept),
        .active   (active[i]),
        .sig_byte (aligned_sig[i*BYTE_W +: BYTE_W]),
        .byte_in  (chain[i]),
        .hit_in   (hit_chain[i]),
        .byte_q   (chain[i+1]),
        .hit_out  (hit_chain[i+1])
      );
    end else begin : g_end
      bsc_cell u_cell (
        .clk      (clk),
        .shift    (accept),
        .active   (active[i]),
        .sig_byte (aligned_sig[i*BYTE_W +: BYTE_W]),
        .byte_in  (chain[i]),
        .hit_in   (hit_chain[i]),
        .byte_q   (),
        .hit_out  (hit_chain[i+1])
      );
    end
  end

  // window complete once position + 1 reaches len (modulo 2^64)
  assign hit    = hit_chain[SIG_MAX];
  assign pos_ok = ((position + ADDR_W'(1)) >= ADDR_W'(len));

  // look-back distances from the current byte to the first captured byte
  assign back_before = BACK_W'(len) + BACK_W'(dist_sat) + BACK_W'(CAPTURE_BYTES - 2);
  assign back_after  = BACK_W'(len) - BACK_W'(1) - BACK_W'(dist_sat);
  assign cd_dec      = (cd != '0) ? cd - CD_W'(1) : cd;

  // per-byte decision and next scan state
  always_comb begin
    res_valid     = 1'b0;
    res_status    = ST_FOUND;
    res_capture   = 1'b0;
    res_addr_mode = 1'b0;
    res_back      = '0;
    found_next    = found;
    reported_next = reported;
    cd_next       = cd;
    if (!reported) begin
      if (found) begin
        // waiting for the bytes after the match
        cd_next = cd_dec;
        if (cd_dec == '0) begin
          res_valid   = 1'b1;
          res_capture = 1'b1;
          res_back    = BACK_W'(CAPTURE_BYTES - 1);
        end
      end else if (pos_ok && hit) begin
        found_next = 1'b1;
        if (!want_data) begin
          res_valid     = 1'b1;
          res_addr_mode = 1'b1;
        end else if (!after_match) begin
          res_valid = 1'b1;
          if ((position < ADDR_W'(back_before)) || (32'(back_before) >= HISTORY_DEPTH)) begin
            res_status = ST_OUTSIDE;
          end else begin
            res_capture = 1'b1;
            res_back    = back_before;
          end
        end else if ((BACK_W'(dist_sat) + BACK_W'(CAPTURE_BYTES)) <= BACK_W'(len)) begin
          res_valid   = 1'b1;
          res_capture = 1'b1;
          res_back    = back_after;
        end else begin
          cd_next = CD_W'(dist_sat) + CD_W'(CAPTURE_BYTES) - CD_W'(len);
        end
      end
      // region closes without a result yet
      if (last_byte && !res_valid) begin
        res_valid  = 1'b1;
        res_status = found_next ? ST_OUTSIDE : ST_NOT_FOUND;
      end
      if (res_valid) begin
        reported_next = 1'b1;
      end
    end
    if (last_byte) begin
      found_next    = 1'b0;
      reported_next = 1'b0;
      cd_next       = '0;
    end
  end

  // position and write slot advance, restart at region end
  always_comb begin
    if (last_byte) begin
      position_next = '0;
      wr_slot_next  = '0;
    end else begin
      position_next = position + ADDR_W'(1);
      wr_slot_next  = (wr_slot == SLOT_W'(RING - 1)) ? '0 : wr_slot + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      found    <= 1'b0;
      reported <= 1'b0;
      cd       <= '0;
      wr_slot  <= '0;
    end else if (accept) begin
      position <= position_next;
      found    <= found_next;
      reported <= reported_next;
      cd       <= cd_next;
      wr_slot  <= wr_slot_next;
    end
  end

  // ring slot of the first captured byte
  assign slot_sub   = SUB_W'(wr_slot) + SUB_W'(RING) - SUB_W'(res_back);
  assign first_slot = (slot_sub >= SUB_W'(RING)) ? SLOT_W'(slot_sub - SUB_W'(RING))
                                                 : SLOT_W'(slot_sub);

  // signed offset from position to reported address
  assign res_delta = after_match
                   ? DELTA_W'(1) - DELTA_W'(len) + DELTA_W'(dist_sat)
                   : DELTA_W'(1) - DELTA_W'(len) - DELTA_W'(dist_sat);

  // stage 1: decision registered, byte now in RAM
  always_ff @(posedge clk) begin
    if (rst) begin
      t1_valid <= 1'b0;
    end else begin
      t1_valid <= accept && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    t1.status    <= res_status;
    t1.capture   <= res_capture;
    t1.addr_mode <= res_addr_mode;
    t1.slot      <= first_slot;
    t1.position  <= position;
    t1.delta     <= res_delta;
  end

  // history banks, byte offset modulo eight selects the bank
  always_comb begin
    for (int b = 0; b < BANKS; b++) begin
      if (BANK_W'(b) < t1.slot[BANK_W-1:0]) begin
        rd_row[b] = (t1.slot[SLOT_W-1:BANK_W] == ROW_W'(ROWS - 1))
                  ? '0 : t1.slot[SLOT_W-1:BANK_W] + ROW_W'(1);
      end else begin
        rd_row[b] = t1.slot[SLOT_W-1:BANK_W];
      end
    end
  end

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    bsc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (ROWS)
    ) u_ram (
      .clk   (clk),
      .we    (accept && (wr_slot[BANK_W-1:0] == BANK_W'(b))),
      .waddr (wr_slot[SLOT_W-1:BANK_W]),
      .wdata (byte_item.mem_byte),
      .raddr (rd_row[b]),
      .rdata (ram_q[b])
    );
  end

  // stage 2: offset from region start, RAM data arrives
  always_ff @(posedge clk) begin
    if (rst) begin
      t2_valid <= 1'b0;
    end else begin
      t2_valid <= t1_valid;
    end
  end

  always_ff @(posedge clk) begin
    t2.status    <= t1.status;
    t2.capture   <= t1.capture;
    t2.addr_mode <= t1.addr_mode;
    t2.bank      <= t1.slot[BANK_W-1:0];
    t2.offset    <= t1.position + {{(ADDR_W-DELTA_W){t1.delta[DELTA_W-1]}}, t1.delta};
  end

  // rotate bank outputs so the first byte lands lowest
  always_comb begin
    logic [BANK_W-1:0] idx;
    idx = '0;
    for (int k = 0; k < CAPTURE_BYTES; k++) begin
      idx = t2.bank + BANK_W'(k);
      captured[k*BYTE_W +: BYTE_W] = ram_q[idx];
    end
  end

  // result assembly
  always_comb begin
    push_item.status        = t2.status;
    push_item.match_address = t2.addr_mode ? base_address + t2.offset : '0;
    push_item.data_value    = t2.capture ? captured : '0;
  end

  assign pop = result_valid && !result_stall;

  bsc_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (t2_valid),
    .push_item (push_item),
    .pop       (pop),
    .valid     (result_valid),
    .head      (result_item),
    .count     (q_count)
  );

  // every result in flight already has a queue entry reserved
  assign queued     = {1'b0, q_count} + (OCNT_W+1)'(t1_valid) + (OCNT_W+1)'(t2_valid);
  assign byte_stall = (queued >= (OCNT_W+1)'(OUT_DEPTH));

  `CHK_SAME(a_queue_credit, 1'b1, queued <= (OCNT_W+1)'(OUT_DEPTH),
    "results in flight exceed queue capacity")
  `CHK_SAME(a_single_result, accept && reported, !res_valid,
    "second result in one region")
  `CHK_SAME(a_countdown_state, cd != '0, found && !reported,
    "capture countdown running without a pending match")
  `CHK_NEXT(a_capture_flow, t1_valid && t1.capture, t2_valid && t2.capture,
    "capture transaction lost between pipeline stages")

endmodule

`default_nettype wire

FILE: tb/sv/byte_signature_scanner_tb.sv
// Self-checking testbench for byte_signature_scanner: region streams checked against a local predictor.
`timescale 1ns / 1ps

module byte_signature_scanner_tb
  import bsc_pkg::*;
();

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 8;     // margin for results still in the pipeline
  localparam int QUIET_LIMIT   = 4000;  // cycles with no transaction before giving up
  localparam int PHASE_BYTES   = 400;
  localparam int CHUNK_BYTES   = 100;   // bytes streamed per register setting
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;  // unmapped index, must be ignored

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  byte_valid = 1'b0;
  logic                  byte_stall;
  scan_in_t              byte_item = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  scan_out_t             result_item;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int idle_pct = 0;
  int stall_pct = 0;
  int error_count = 0;
  int bytes_sent = 0;
  int regions_sent = 0;
  int results_checked = 0;
  int settings_written = 0;
  int quiet_cycles = 0;

  // register shadow
  logic [63:0] mir_sig_lo, mir_sig_hi, mir_base;
  logic [4:0]  mir_len;
  logic [7:0]  mir_dist;
  logic        mir_after, mir_want;

  // scan state shadow
  logic [7:0]  scan_hist [HISTORY_DEPTH_DEF];
  logic [63:0] scan_pos, match_off;
  logic        seen_match, result_sent;
  int          capture_left;

  scan_out_t expected_results[$];

  byte_signature_scanner DUT (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int eff_sig_len();
    if (mir_len == 0) return 1;
    if (mir_len > SIG_MAX_DEF) return SIG_MAX_DEF;
    return int'(mir_len);
  endfunction

  function automatic logic [7:0] sig_byte_at(int j);
    if (j < 8) return mir_sig_lo[8*j +: 8];
    return mir_sig_hi[8*(j-8) +: 8];
  endfunction

  // eight history bytes starting at a region offset, first byte lowest
  function automatic logic [63:0] gather_window(logic [63:0] first);
    logic [63:0] v;
    v = '0;
    for (int k = 0; k < CAPTURE_BYTES; k++)
      v[8*k +: 8] = scan_hist[(first + k) % HISTORY_DEPTH_DEF];
    return v;
  endfunction

  function automatic void queue_result(status_t st, logic [63:0] addr, logic [63:0] data);
    scan_out_t r;
    r.status        = st;
    r.match_address = addr;
    r.data_value    = data;
    expected_results.push_back(r);
    result_sent = 1'b1;
  endfunction

  function automatic void reset_predictor();
    mir_sig_lo = '0;
    mir_sig_hi = '0;
    mir_len    = 5'd1;
    mir_dist   = '0;
    mir_after  = 1'b0;
    mir_want   = 1'b0;
    mir_base   = '0;
    scan_pos     = '0;
    match_off    = '0;
    seen_match   = 1'b0;
    result_sent  = 1'b0;
    capture_left = 0;
    foreach (scan_hist[i]) scan_hist[i] = '0;
    expected_results.delete();
  endfunction

  function automatic void mirror_reg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    case (idx)
      REG_SIG_LOW:      mir_sig_lo = data;
      REG_SIG_HIGH:     mir_sig_hi = data;
      REG_SIG_LEN:      mir_len    = data[4:0];
      REG_DISTANCE:     mir_dist   = data[7:0];
      REG_AFTER_MATCH:  mir_after  = data[0];
      REG_WANT_DATA:    mir_want   = data[0];
      REG_BASE_ADDRESS: mir_base   = data;
      default: ;
    endcase
  endfunction

  // one accepted byte: update the scan state and queue the result it causes, if any
  function automatic void predict_scan(scan_in_t it);
    int          len;
    int          dist_sat;
    bit          hit;
    logic [63:0] start;
    logic [63:0] need;
    len      = eff_sig_len();
    dist_sat = int'(mir_dist);  // an 8-bit register never exceeds MAX_DISTANCE
    scan_hist[scan_pos % HISTORY_DEPTH_DEF] = it.mem_byte;

    if (!result_sent) begin
      if (seen_match) begin
        // waiting for the capture window after the match to fill
        if (capture_left > 0) capture_left--;
        if (capture_left == 0)
          queue_result(ST_FOUND, '0, gather_window(match_off + 64'(dist_sat)));
      end else if (scan_pos + 64'd1 >= 64'(len)) begin
        start = scan_pos + 64'd1 - 64'(len);
        hit = 1'b1;
        for (int j = 0; j < len; j++)
          if (scan_hist[(start + j) % HISTORY_DEPTH_DEF] != sig_byte_at(j)) hit = 1'b0;
        if (hit) begin
          seen_match = 1'b1;
          match_off  = start;
          if (!mir_want) begin
            if (mir_after) queue_result(ST_FOUND, mir_base + start + 64'(dist_sat), '0);
            else queue_result(ST_FOUND, mir_base + start - 64'(dist_sat), '0);
          end else if (!mir_after) begin
            // window ends before the match: may fall ahead of the region
            need = 64'(dist_sat + CAPTURE_BYTES - 1);
            if (start < need || 64'(len - 1) + need >= 64'(HISTORY_DEPTH_DEF))
              queue_result(ST_OUTSIDE, '0, '0);
            else
              queue_result(ST_FOUND, '0, gather_window(start - need));
          end else if (dist_sat + CAPTURE_BYTES - 1 <= len - 1) begin
            queue_result(ST_FOUND, '0, gather_window(start + 64'(dist_sat)));
          end else begin
            capture_left = dist_sat + CAPTURE_BYTES - 1 - (len - 1);
          end
        end
      end
      // region closes with nothing reported yet
      if (it.region_end && !result_sent) begin
        if (seen_match) queue_result(ST_OUTSIDE, '0, '0);
        else queue_result(ST_NOT_FOUND, '0, '0);
      end
    end

    if (it.region_end) begin
      scan_pos     = '0;
      seen_match   = 1'b0;
      result_sent  = 1'b0;
      capture_left = 0;
    end else begin
      scan_pos = scan_pos + 64'd1;
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $time);
    error_count++;
  endtask

  task automatic check_result(scan_out_t got);
    scan_out_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with none pending, status", '0, {62'b0, got.status});
    end else begin
      want = expected_results.pop_front();
      results_checked++;
      if (got.status !== want.status)
        report_mismatch("status", {62'b0, want.status}, {62'b0, got.status});
      if (got.match_address !== want.match_address)
        report_mismatch("match_address", want.match_address, got.match_address);
      if (got.data_value !== want.data_value)
        report_mismatch("data_value", want.data_value, got.data_value);
    end
  endtask

  // sample every transaction at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      reset_predictor();
    end else begin
      if (result_valid && !result_stall) check_result(result_item);
      if (cfg_wr_en) mirror_reg_write(cfg_index, cfg_data);
      if (byte_valid && !byte_stall) predict_scan(byte_item);
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (result_valid && !result_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- driving

  task automatic send_byte(logic [7:0] b, logic last);
    scan_in_t it;
    it.mem_byte   = b;
    it.region_end = last;
    while ($urandom_range(99) < idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= it;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // stop sending until every expected result is in; optionally let the pipe settle
  task automatic hold_until_drained(bit settle);
    byte_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic program_scanner(input logic [63:0] sig_lo, input logic [63:0] sig_hi,
                                 input logic [4:0] len, input logic [7:0] dist_val,
                                 input logic after, input logic want,
                                 input logic [63:0] base);
    write_reg(REG_SIG_LOW, sig_lo);
    write_reg(REG_SIG_HIGH, sig_hi);
    write_reg(REG_SPARE, {$urandom, $urandom});
    write_reg(REG_SIG_LEN, 64'(len));
    write_reg(REG_DISTANCE, 64'(dist_val));
    write_reg(REG_AFTER_MATCH, 64'(after));
    write_reg(REG_WANT_DATA, 64'(want));
    write_reg(REG_BASE_ADDRESS, base);
    cfg_wr_en <= 1'b0;
    settings_written++;
  endtask

  function automatic logic [7:0] filler_byte();
    if ($urandom_range(3) == 0) return sig_byte_at($urandom_range(eff_sig_len() - 1));
    return 8'($urandom);
  endfunction

  // filler, then the signature (or a broken prefix of it), then filler; last byte ends region
  task automatic send_region(int pre, int sig_count, bit broken, int tail);
    logic [7:0] stream_bytes[$];
    repeat (pre) stream_bytes.push_back(filler_byte());
    for (int j = 0; j < sig_count; j++) stream_bytes.push_back(sig_byte_at(j));
    if (broken) stream_bytes.push_back(~sig_byte_at(sig_count));
    repeat (tail) stream_bytes.push_back(filler_byte());
    if (stream_bytes.size() == 0) stream_bytes.push_back(filler_byte());
    foreach (stream_bytes[i]) send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
    regions_sent++;
  endtask

  task automatic random_config();
    logic [63:0] lo, hi, base;
    logic [4:0]  len;
    logic [7:0]  dist_val;
    case ($urandom_range(3))
      0:       begin lo = '0; hi = '0; end
      1:       begin lo = '1; hi = '1; end
      default: begin lo = {$urandom, $urandom}; hi = {$urandom, $urandom}; end
    endcase
    case ($urandom_range(2))
      0:       len = 5'($urandom_range(0, 31));
      1:       len = 5'($urandom_range(1, 4));
      default: len = 5'($urandom_range(5, 16));
    endcase
    case ($urandom_range(9))
      0, 1:    dist_val = 8'd0;
      2:       dist_val = 8'd255;
      3, 4:    dist_val = 8'($urandom_range(0, 255));
      default: dist_val = 8'($urandom_range(0, 15));
    endcase
    case ($urandom_range(3))
      0:       base = '0;
      1:       base = '1;
      default: base = {$urandom, $urandom};
    endcase
    program_scanner(lo, hi, len, dist_val, 1'($urandom_range(1)), 1'($urandom_range(1)), base);
  endtask

  // mostly well-formed regions, some broken prefixes and pure noise
  task automatic random_region();
    int eff;
    int d;
    int kind;
    int pre;
    int tail;
    eff  = eff_sig_len();
    d    = int'(mir_dist);
    kind = $urandom_range(99);
    if (kind < 70) begin
      if (mir_want && !mir_after && $urandom_range(1)) pre = $urandom_range(d, d + 12);
      else pre = $urandom_range(0, 6);
      if (mir_want && mir_after && $urandom_range(1)) tail = $urandom_range(d, d + 10);
      else tail = $urandom_range(0, 4);
      // now and then a region near or beyond the history depth
      if ($urandom_range(39) == 0) pre = $urandom_range(500, 560);
      send_region(pre, eff, 1'b0, tail);
    end else if (kind < 85) begin
      send_region($urandom_range(0, 6), $urandom_range(0, eff - 1), 1'b1, $urandom_range(0, 4));
    end else begin
      send_region($urandom_range(1, 12), 0, 1'b0, 0);
    end
    if ($urandom_range(9) == 0) hold_until_drained(1'b0);
  endtask

  task automatic run_random_phase(int idle, int stall, int phase_no);
    int goal;
    int chunk_end;
    bit first_setting;
    idle_pct = idle;
    stall_pct = stall;
    goal = bytes_sent + PHASE_BYTES;
    first_setting = 1'b1;
    while (bytes_sent < goal) begin
      hold_until_drained(1'b1);
      // each phase opens at the register extremes
      if (first_setting) program_scanner('1, '1, 5'd31, 8'd255, phase_no[0], phase_no[1], '1);
      else random_config();
      first_setting = 1'b0;
      chunk_end = bytes_sent + CHUNK_BYTES;
      while (bytes_sent < chunk_end && bytes_sent < goal) random_region();
    end
  endtask

  // ---------------------------------------------------------------- tests

  // reset values: one-byte zero signature, address mode, no offset
  task automatic test_reset_values();
    send_byte(8'h5A, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hC3, 1'b1);
    hold_until_drained(1'b1);
  endtask

  task automatic test_directed_cases();
    // address after match, wrapping past 2^64; match on the last byte
    program_scanner(64'hBBAA, '0, 5'd2, 8'd3, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFE);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hBB, 1'b1);
    // region with no match
    send_byte(8'h7E, 1'b1);
    hold_until_drained(1'b1);

    // zero length acts as one; capture before the region start
    program_scanner(64'hAA, '0, 5'd0, 8'd0, 1'b0, 1'b1, 64'h1000);
    send_byte(8'hAA, 1'b1);
    hold_until_drained(1'b1);

    // capture before the match, window starting exactly at offset zero
    program_scanner(64'hAA, '0, 5'd1, 8'd0, 1'b0, 1'b1, '0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h66, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'hAA, 1'b1);
    hold_until_drained(1'b1);

    // capture after the match: completes, then later bytes are ignored
    program_scanner(64'hBBAA, '0, 5'd2, 8'd0, 1'b1, 1'b1, '0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hBB, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'h08, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h80, 1'b1);
    // region ends before the capture window fills
    send_byte(8'hAA, 1'b0);
    send_byte(8'hBB, 1'b0);
    send_byte(8'h40, 1'b1);
    hold_until_drained(1'b1);
  endtask

  task automatic test_full_rate();
    run_random_phase(0, 0, 0);
  endtask

  task automatic test_sender_gaps();
    run_random_phase(83, 0, 1);
  endtask

  task automatic test_receiver_stalls();
    run_random_phase(0, 83, 2);
  endtask

  task automatic test_both_throttled();
    run_random_phase(30, 30, 3);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_directed_cases();
    test_full_rate();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_throttled();
    hold_until_drained(1'b1);
    $display("Scanned %0d bytes in %0d regions under %0d register settings; %0d results compared.",
             bytes_sent, regions_sent, settings_written, results_checked);
    $display("Ran back-to-back, sender-gap, receiver-stall and mixed throttling; %0d mismatches.",
             error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/bsc_pkg.sv
sv/bsc_cell.sv
sv/bsc_ram.sv
sv/bsc_out_fifo.sv
sv/byte_signature_scanner.sv
tb/sv/byte_signature_scanner_tb.sv
